// ===== sv/tsta_pkg.sv =====
// shared types and codes of the time slot table allocator
// no dependencies; every other file imports this package
package tsta_pkg;

  localparam int unsigned CodeW      = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_QUERY      = 2'd0,
    CMD_SET_THREAD = 2'd1,
    CMD_SET_SOFT   = 2'd2,
    CMD_RSVD       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_NO_ROOM   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_SET,
    OP_REJECT
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [CodeW-1:0] who;
    logic [3:0]       want;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COUNT,
    BK_DECIDE,
    BK_WRITE,
    BK_DONE
  } bk_state_e;

endpackage

// ===== sv/tsta_front.sv =====
// front end: takes command transfers, checks parameters and turns them into ops
// depends on tsta_pkg
module tsta_front #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned SOFT_CODE = 14
) (
  input  logic          start_i,
  input  logic [1:0]    cmd_i,
  input  logic [2:0]    owner_id_i,
  input  logic [3:0]    requested_count_i,
  input  logic          full_i,
  output logic          busy_o,
  output logic          push_o,
  output tsta_pkg::op_t op_o
);
  import tsta_pkg::*;

  logic too_big;

  assign busy_o  = full_i;
  assign push_o  = start_i && !full_i;
  assign too_big = {1'b0, requested_count_i} >= 5'(NUM_SLOTS - 1);

  always_comb begin
    op_o.who  = {1'b0, owner_id_i};
    op_o.want = requested_count_i;
    op_o.kind = OP_REJECT;
    unique case (cmd_e'(cmd_i))
      CMD_QUERY: begin
        op_o.kind = OP_QUERY;
      end
      CMD_SET_THREAD: begin
        op_o.kind = too_big ? OP_REJECT : OP_SET;
      end
      CMD_SET_SOFT: begin
        op_o.who  = CodeW'(SOFT_CODE);
        op_o.kind = too_big ? OP_REJECT : OP_SET;
      end
      CMD_RSVD: begin
        op_o.kind = OP_REJECT;
      end
      default: begin
        op_o.kind = OP_REJECT;
      end
    endcase
  end

endmodule

// ===== sv/tsta_queue.sv =====
// short op queue between front end and slot sequencer
// depends on tsta_pkg
module tsta_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsta_pkg::op_t op_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output tsta_pkg::op_t op_o
);
  import tsta_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= op_i;
    end
  end

endmodule

// ===== sv/tsta_back.sv =====
// slot sequencer: owns the slot table, walks it once to count and, for a set that changes it, again to update
// depends on tsta_pkg
module tsta_back #(
  parameter int unsigned NUM_SLOTS     = 8,
  parameter int unsigned SOFT_CODE     = 14,
  parameter int unsigned DISABLED_CODE = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  tsta_pkg::op_t q_op_i,
  output logic          pop_o,
  output logic          idle_o,
  output logic          done_o,
  output logic [1:0]    status_o,
  output logic [3:0]    owner_slots_o,
  output logic [3:0]    soft_slots_o,
  output logic [3:0]    active_slots_o
);
  import tsta_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SumW = ((CntW > 4) ? CntW : 4) + 1;
  localparam logic [CodeW-1:0] DisCode  = CodeW'(DISABLED_CODE);
  localparam logic [CodeW-1:0] SoftCode = CodeW'(SOFT_CODE);

  logic [CodeW-1:0] slot_q [NUM_SLOTS];

  bk_state_e        state_q, state_d;
  op_t              op_q, op_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  own_q, own_d, soft_q, soft_d, act_q, act_d;
  logic [SumW-1:0]  left_q, left_d;
  logic             fill_q, fill_d;
  status_e          status_q, status_d;
  logic             done_q, done_d;

  logic [CodeW-1:0] cur, wr_data;
  logic             wr_en, hit, is_dis, is_soft, last;
  logic [SumW-1:0]  want_x, own_x, act_x, gap;

  assign cur     = slot_q[idx_q];
  assign hit     = cur == op_q.who;
  assign is_dis  = cur == DisCode;
  assign is_soft = cur == SoftCode;
  assign last    = idx_q == IdxW'(NUM_SLOTS - 1);
  assign want_x  = SumW'(op_q.want);
  assign own_x   = SumW'(own_q);
  assign act_x   = SumW'(act_q);
  assign idle_o  = state_q == BK_IDLE;
  assign done_o  = done_q;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    idx_d    = idx_q;
    own_d    = own_q;
    soft_d   = soft_q;
    act_d    = act_q;
    left_d   = left_q;
    fill_d   = fill_q;
    status_d = status_q;
    done_d   = 1'b0;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    wr_data  = fill_q ? op_q.who : DisCode;
    gap      = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o    = 1'b1;
          op_d     = q_op_i;
          idx_d    = '0;
          own_d    = '0;
          soft_d   = '0;
          act_d    = '0;
          status_d = (q_op_i.kind == OP_REJECT) ? ST_BAD_PARAM : ST_OK;
          state_d  = (q_op_i.kind == OP_REJECT) ? BK_DONE : BK_COUNT;
        end
      end
      BK_COUNT: begin
        if (hit) begin
          own_d = own_q + CntW'(1);
        end else if (is_soft) begin
          soft_d = soft_q + CntW'(1);
        end
        // a slot equal to the owner counts active even when the owner is the disabled code
        if (hit || !is_dis) begin
          act_d = act_q + CntW'(1);
        end
        idx_d = idx_q + IdxW'(1);
        if (last) begin
          idx_d   = '0;
          state_d = (op_q.kind == OP_QUERY) ? BK_DONE : BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        idx_d = '0;
        if (want_x == own_x) begin
          state_d = BK_DONE;
        end else if (want_x > own_x) begin
          gap = want_x - own_x;
          if (act_x + gap > SumW'(NUM_SLOTS - 1)) begin
            status_d = ST_NO_ROOM;
            state_d  = BK_DONE;
          end else begin
            fill_d  = 1'b1;
            left_d  = gap;
            state_d = BK_WRITE;
          end
        end else begin
          fill_d  = 1'b0;
          left_d  = own_x - want_x;
          state_d = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (left_q != '0 && (fill_q ? is_dis : hit)) begin
          wr_en  = 1'b1;
          left_d = left_q - SumW'(1);
        end
        idx_d = idx_q + IdxW'(1);
        if (last || left_d == '0) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        done_d  = 1'b1;
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_q[i] <= (i == 0) ? '0 : DisCode;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (wr_en) begin
        slot_q[idx_q] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    own_q    <= own_d;
    soft_q   <= soft_d;
    act_q    <= act_d;
    left_q   <= left_d;
    fill_q   <= fill_d;
    status_q <= status_d;
    if (state_q == BK_DONE) begin
      status_o <= status_q;
      // counts only go out for queries, kept to four bits
      if (op_q.kind == OP_QUERY) begin
        owner_slots_o  <= own_q[3:0];
        soft_slots_o   <= soft_q[3:0];
        active_slots_o <= act_q[3:0];
      end else begin
        owner_slots_o  <= '0;
        soft_slots_o   <= '0;
        active_slots_o <= '0;
      end
    end
  end

endmodule

// ===== sv/time_slot_table_allocator_top.sv =====
// Time slot table allocator. A command is taken when start is high and busy is low;
// up to two commands wait in a queue while the sequencer works. The sequencer walks the
// slot table one slot per cycle: a query walks it once to count, a rejected command goes
// straight to its result, and a set counts, decides and, if the table must change, walks
// it again to write. Each result appears for one cycle with done_o high and must be
// taken then; the block never holds a result back.
// depends on tsta_pkg, tsta_front, tsta_queue, tsta_back
module time_slot_table_allocator_top #(
  parameter int unsigned NUM_SLOTS     = 8,
  parameter int unsigned SOFT_CODE     = 14,
  parameter int unsigned DISABLED_CODE = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd_i,
  input  logic [2:0] owner_id_i,
  input  logic [3:0] requested_count_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [3:0] owner_slots_o,
  output logic [3:0] soft_slots_o,
  output logic [3:0] active_slots_o
);
  import tsta_pkg::*;

  logic push, full, q_valid, pop, back_idle;
  op_t  push_op, head_op;

  tsta_front #(
    .NUM_SLOTS(NUM_SLOTS),
    .SOFT_CODE(SOFT_CODE)
  ) u_front (
    .start_i          (start),
    .cmd_i            (cmd_i),
    .owner_id_i       (owner_id_i),
    .requested_count_i(requested_count_i),
    .full_i           (full),
    .busy_o           (busy),
    .push_o           (push),
    .op_o             (push_op)
  );

  tsta_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(q_valid),
    .op_o   (head_op)
  );

  tsta_back #(
    .NUM_SLOTS    (NUM_SLOTS),
    .SOFT_CODE    (SOFT_CODE),
    .DISABLED_CODE(DISABLED_CODE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_op_i        (head_op),
    .pop_o         (pop),
    .idle_o        (back_idle),
    .done_o        (done_o),
    .status_o      (status_o),
    .owner_slots_o (owner_slots_o),
    .soft_slots_o  (soft_slots_o),
    .active_slots_o(active_slots_o)
  );

`ifndef SYNTH
  // each op passes through the done state, so results never come back to back
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("two results in consecutive cycles");

  // the sequencer only takes a new op when idle and the queue has one
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_valid && back_idle)) else $error("pop while busy or queue empty");

  // any non-ok status comes from a set or reject, which report zero counts
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (owner_slots_o == '0 && soft_slots_o == '0 && active_slots_o == '0))
    else $error("counts reported with an error status");

  // a transfer into a full queue would be lost
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");
`endif

endmodule

// ===== sim/tb_time_slot_table_allocator_top.sv =====
// testbench for the time slot table allocator: directed and random commands with a
// slot table predictor held in a small scoreboard class
// depends on tsta_pkg and time_slot_table_allocator_top
module tb_time_slot_table_allocator_top;
  import tsta_pkg::*;

  localparam int unsigned   NumSlots  = 8;
  localparam logic [3:0]    SoftCode  = 4'd14;
  localparam logic [3:0]    DisCode   = 4'd15;
  localparam int unsigned   NumRandom = 850;
  localparam int unsigned   Limit     = 200000;
  localparam int unsigned   Settle    = 30;

  typedef struct {
    status_e    st;
    logic [3:0] own;
    logic [3:0] soft_n;
    logic [3:0] act;
  } slot_answer_t;

  class slot_scoreboard;
    logic [3:0]   slot_map [NumSlots];
    slot_answer_t answers [$];
    int unsigned  errors;

    function new();
      int i;
      for (i = 0; i < NumSlots; i++) slot_map[i] = DisCode;
      slot_map[0] = 4'd0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned pending();
      return answers.size();
    endfunction

    // raise fills the lowest disabled slots, lower frees the lowest owned ones
    function status_e resize_owner(input logic [3:0] who, input int unsigned want);
      int unsigned owned;
      int unsigned active;
      int unsigned left;
      int i;
      owned  = 0;
      active = 0;
      for (i = 0; i < NumSlots; i++) begin
        if (slot_map[i] == who) begin
          owned++;
          active++;
        end else if (slot_map[i] != DisCode) begin
          active++;
        end
      end
      if (want == owned) return ST_OK;
      if (want > owned) begin
        left = want - owned;
        if (active + left > NumSlots - 1) return ST_NO_ROOM;
        for (i = 0; i < NumSlots && left != 0; i++) begin
          if (slot_map[i] == DisCode) begin
            slot_map[i] = who;
            left--;
          end
        end
      end else begin
        left = owned - want;
        for (i = 0; i < NumSlots && left != 0; i++) begin
          if (slot_map[i] == who) begin
            slot_map[i] = DisCode;
            left--;
          end
        end
      end
      return ST_OK;
    endfunction

    function void note(input cmd_e c, input logic [2:0] owner, input logic [3:0] want);
      slot_answer_t a;
      int i;
      a.st     = ST_OK;
      a.own    = '0;
      a.soft_n = '0;
      a.act    = '0;
      case (c)
        CMD_QUERY: begin
          for (i = 0; i < NumSlots; i++) begin
            if (slot_map[i] == {1'b0, owner}) a.own++;
            else if (slot_map[i] == SoftCode) a.soft_n++;
            if (slot_map[i] != DisCode) a.act++;
          end
        end
        CMD_SET_THREAD, CMD_SET_SOFT: begin
          if (want >= NumSlots - 1) a.st = ST_BAD_PARAM;
          else if (c == CMD_SET_THREAD) a.st = resize_owner({1'b0, owner}, want);
          else a.st = resize_owner(SoftCode, want);
        end
        default: a.st = ST_BAD_PARAM;
      endcase
      answers.push_back(a);
    endfunction

    task check(input logic [1:0] st, input logic [3:0] own, input logic [3:0] soft_n,
               input logic [3:0] act);
      slot_answer_t a;
      if (answers.size() == 0) begin
        report("result with no command pending");
      end else begin
        a = answers.pop_front();
        if (st !== a.st)
          report($sformatf("status %0d, expected %0d", st, a.st));
        if (own !== a.own)
          report($sformatf("owner_slots %0d, expected %0d", own, a.own));
        if (soft_n !== a.soft_n)
          report($sformatf("soft_slots %0d, expected %0d", soft_n, a.soft_n));
        if (act !== a.act)
          report($sformatf("active_slots %0d, expected %0d", act, a.act));
      end
    endtask
  endclass

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       start             = 1'b0;
  logic       busy;
  logic [1:0] cmd_i             = '0;
  logic [2:0] owner_id_i        = '0;
  logic [3:0] requested_count_i = '0;
  logic       done_o;
  logic [1:0] status_o;
  logic [3:0] owner_slots_o;
  logic [3:0] soft_slots_o;
  logic [3:0] active_slots_o;

  slot_scoreboard sb;
  bit             idle_en = 1'b1;
  int unsigned    cycles  = 0;

  time_slot_table_allocator_top #(
    .NUM_SLOTS    (NumSlots),
    .SOFT_CODE    (SoftCode),
    .DISABLED_CODE(DisCode)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .owner_id_i       (owner_id_i),
    .requested_count_i(requested_count_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .owner_slots_o    (owner_slots_o),
    .soft_slots_o     (soft_slots_o),
    .active_slots_o   (active_slots_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check(status_o, owner_slots_o, soft_slots_o, active_slots_o);
  end

  task automatic send_cmd(input cmd_e c, input logic [2:0] owner, input logic [3:0] want);
    if (idle_en) begin
      while ($urandom_range(99) < 13) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start             <= 1'b1;
    cmd_i             <= c;
    owner_id_i        <= owner;
    requested_count_i <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(c, owner, want);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed requests with small counts so the table keeps moving
  task automatic send_random();
    int unsigned r;
    cmd_e        c;
    logic [3:0]  want;
    r = $urandom_range(99);
    if (r < 35) c = CMD_QUERY;
    else if (r < 70) c = CMD_SET_THREAD;
    else if (r < 92) c = CMD_SET_SOFT;
    else c = CMD_RSVD;
    r = $urandom_range(99);
    if (r < 50) want = 4'($urandom_range(3));
    else if (r < 88) want = 4'($urandom_range(6));
    else want = 4'($urandom_range(15));
    send_cmd(c, 3'($urandom_range(7)), want);
  endtask

  initial begin
    int i;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_QUERY, 3'd0, 4'd0);
    send_cmd(CMD_QUERY, 3'd7, 4'd15);
    send_cmd(CMD_RSVD, 3'd5, 4'd9);
    send_cmd(CMD_SET_THREAD, 3'd2, 4'd7);     // count too large, at the boundary
    send_cmd(CMD_SET_THREAD, 3'd2, 4'd15);
    send_cmd(CMD_SET_THREAD, 3'd0, 4'd1);     // already met
    send_cmd(CMD_SET_THREAD, 3'd1, 4'd6);     // fills the table
    send_cmd(CMD_SET_SOFT, 3'd6, 4'd1);       // no room left
    send_cmd(CMD_QUERY, 3'd1, 4'd8);
    send_cmd(CMD_SET_THREAD, 3'd1, 4'd2);     // lower
    send_cmd(CMD_SET_SOFT, 3'd2, 4'd3);
    send_cmd(CMD_QUERY, 3'd1, 4'd0);
    send_cmd(CMD_QUERY, 3'd6, 4'd5);
    send_cmd(CMD_SET_THREAD, 3'd7, 4'd2);
    send_cmd(CMD_SET_THREAD, 3'd7, 4'd1);
    send_cmd(CMD_SET_THREAD, 3'd0, 4'd0);
    send_cmd(CMD_SET_SOFT, 3'd1, 4'd0);
    send_cmd(CMD_QUERY, 3'd7, 4'd10);
    send_cmd(CMD_SET_THREAD, 3'd5, 4'd4);
    send_cmd(CMD_QUERY, 3'd5, 4'd3);
    send_cmd(CMD_SET_THREAD, 3'd4, 4'd6);
    send_cmd(CMD_SET_SOFT, 3'd3, 4'd0);
    send_cmd(CMD_QUERY, 3'd4, 4'd12);
    send_cmd(CMD_RSVD, 3'd2, 4'd0);
    drain();

    for (i = 0; i < NumRandom; i++) begin
      idle_en = !(i >= 300 && i < 500);
      if (i == 600) drain();
      send_random();
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tsta_pkg.sv
sv/tsta_front.sv
sv/tsta_queue.sv
sv/tsta_back.sv
sv/time_slot_table_allocator_top.sv
sim/tb_time_slot_table_allocator_top.sv
